>>> rtl/sdmd_pkg.sv
// Shared types, constants and glyph table of the scrolling digit matrix display.
package sdmd_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int MATRIX_ROWS = 5;
    localparam int MATRIX_COLS = 5;

    localparam int NUMBER_W  = 32;
    localparam int VALUE_W   = NUMBER_W - 1;
    localparam int DIGITS_W  = MAX_DIGITS * 4;
    localparam int TOTAL_W   = $clog2(MAX_DIGITS + 1);
    localparam int BITCNT_W  = $clog2(VALUE_W + 1);
    localparam int POS_W     = $clog2((MAX_DIGITS + 1) * MATRIX_COLS + 1) + 1;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int SCAN_W    = 16;
    localparam int SCROLL_W  = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;
    localparam int FIFO_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_PERIOD = 1'd1;

    localparam logic [SCAN_W-1:0]   SCAN_PERIOD_RST   = 16'd250;
    localparam logic [SCROLL_W-1:0] SCROLL_PERIOD_RST = 24'd12500;

    localparam logic [0:0] ACTION_LOAD = 1'b0;
    localparam logic [0:0] ACTION_TICK = 1'b1;

    localparam logic signed [POS_W-1:0] POS_END = POS_W'(-MATRIX_COLS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MATRIX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MATRIX_COLS - 1);

    localparam logic [4:0] GLYPHS [10][5] = '{
        '{5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E},
        '{5'h0E, 5'h02, 5'h0E, 5'h02, 5'h0E},
        '{5'h0A, 5'h0A, 5'h0E, 5'h02, 5'h02},
        '{5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E},
        '{5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E},
        '{5'h0E, 5'h0A, 5'h02, 5'h02, 5'h02},
        '{5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E},
        '{5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E}
    };

    typedef enum logic [1:0] {
        BCD_IDLE,
        BCD_SHIFT,
        BCD_ALIGN
    } bcd_state_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [TOTAL_W-1:0] total;
    } bcd_status_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [4:0]       column_on;
        logic             scrolling;
    } drive_t;

    function automatic logic [4:0] glyph_row(input logic [3:0] digit, input logic [ROW_W-1:0] row);
        logic [3:0] d;
        logic [4:0] bits;
        d    = (digit >= 4'd10) ? digit - 4'd10 : digit;
        bits = 5'd0;
        if (row <= ROW_LAST)
        begin
            bits = GLYPHS[d][row];
        end
        return bits;
    endfunction

endpackage

>>> rtl/sdmd_cmd_if.sv
// Request channel carrying load and tick items into the display.
interface sdmd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [sdmd_pkg::NUMBER_W-1:0] number;

    modport source (output valid, output action, output number, input ready);
    modport sink (input valid, input action, input number, output ready);
endinterface

>>> rtl/sdmd_drive_if.sv
// Result channel carrying one scanned matrix row per transfer.
interface sdmd_drive_if;
    logic                           valid;
    logic                           ready;
    logic [sdmd_pkg::ROW_W-1:0]     row_index;
    logic [4:0]                     column_on;
    logic                           scrolling;

    modport source (output valid, output row_index, output column_on, output scrolling,
                    input ready);
    modport sink (input valid, input row_index, input column_on, input scrolling,
                  output ready);
endinterface

>>> rtl/scrolling_digit_matrix_display_unit.sv
// Top level of the scrolling digit matrix display: timers, frame shifter and row output.
//
// Requests arrive on cmd. A tick request (action 1) advances the row-scan timer and,
// while scrolling, the scroll timer; when the scan timer expires one row and its lit
// columns are registered into the drive queue. A load request (action 0) shows
// 0..9 as a fixed glyph at once; a larger value goes through a bit-serial
// decimal converter, during which cmd is not ready: shift steps, then alignment
// steps that drop leading zeros, then a finishing step. Negative loads are dropped.
// After a tick or a small load, cmd stays ready unless the drive queue is full.
// Scrolling shifts the frame left by one column per scroll period, feeding the
// new right column from the most significant remaining digit.
// drive holds a two-entry queue: cmd stays ready while one row waits, and stalls
// whenever both entries are full, until drive.ready takes a row.
// cfg_wen writes scan_period (index 0) or scroll_period (index 1) at once.
// Reset: blank frame, row 0, timers cleared, periods 250 and 12500.
module scrolling_digit_matrix_display_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [sdmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdmd_pkg::CFG_W-1:0]         cfg_data,
    sdmd_cmd_if.sink                           cmd,
    sdmd_drive_if.source                       drive
);

    logic [sdmd_pkg::SCAN_W-1:0]        scan_period_reg;
    logic [sdmd_pkg::SCROLL_W-1:0]      scroll_period_reg;
    logic [4:0]                         frame_reg [sdmd_pkg::MATRIX_ROWS];
    logic [4:0]                         frame_next [sdmd_pkg::MATRIX_ROWS];
    logic [sdmd_pkg::DIGITS_W-1:0]      digits_reg, digits_next;
    logic [sdmd_pkg::TOTAL_W-1:0]       left_reg, left_next;
    logic [sdmd_pkg::COL_W-1:0]         col_reg, col_next;
    logic signed [sdmd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                               active_reg, active_next;
    logic [sdmd_pkg::ROW_W-1:0]         scan_row_reg, scan_row_next;
    logic [sdmd_pkg::SCAN_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic [sdmd_pkg::SCROLL_W-1:0]      scroll_cnt_reg, scroll_cnt_next;
    sdmd_pkg::drive_t                   slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [sdmd_pkg::FIFO_CNT_W-1:0]    fifo_cnt_reg, fifo_cnt_next;

    sdmd_pkg::bcd_status_t              bcd_status;
    logic [sdmd_pkg::DIGITS_W-1:0]      bcd_digits;

    logic                               accept, load, tick, one_digit, start;
    logic [sdmd_pkg::SCAN_W-1:0]        scan_eff, scan_inc;
    logic [sdmd_pkg::SCROLL_W-1:0]      scroll_eff, scroll_inc;
    logic                               step, emit, pop, wr_low;
    logic [sdmd_pkg::POS_W-1:0]         tp1;
    logic [3:0]                         top_digit;
    logic [4:0]                         new_col;
    sdmd_pkg::drive_t                   row_out;

    assign accept    = cmd.valid && cmd.ready;
    assign load      = accept && (cmd.action == sdmd_pkg::ACTION_LOAD);
    assign tick      = accept && (cmd.action == sdmd_pkg::ACTION_TICK);
    assign one_digit = (cmd.number[sdmd_pkg::NUMBER_W-1:4] == '0) && (cmd.number[3:0] < 4'd10);
    assign start     = load && !cmd.number[sdmd_pkg::NUMBER_W-1] && !one_digit;

    assign cmd.ready = !bcd_status.busy && (fifo_cnt_reg != 2'd2);

    sdmd_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (cmd.number[sdmd_pkg::VALUE_W-1:0]),
        .status (bcd_status),
        .digits (bcd_digits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg   <= sdmd_pkg::SCAN_PERIOD_RST;
            scroll_period_reg <= sdmd_pkg::SCROLL_PERIOD_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                sdmd_pkg::REG_SCAN_PERIOD:   scan_period_reg   <= cfg_data[sdmd_pkg::SCAN_W-1:0];
                sdmd_pkg::REG_SCROLL_PERIOD: scroll_period_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
            begin
                frame_reg[r] <= 5'd0;
            end
            left_reg       <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            active_reg     <= 1'b0;
            scan_row_reg   <= '0;
            scan_cnt_reg   <= '0;
            scroll_cnt_reg <= '0;
            fifo_cnt_reg   <= '0;
        end
        else
        begin
            for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
            begin
                frame_reg[r] <= frame_next[r];
            end
            left_reg       <= left_next;
            col_reg        <= col_next;
            pos_reg        <= pos_next;
            active_reg     <= active_next;
            scan_row_reg   <= scan_row_next;
            scan_cnt_reg   <= scan_cnt_next;
            scroll_cnt_reg <= scroll_cnt_next;
            fifo_cnt_reg   <= fifo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        slot0_reg  <= slot0_next;
        slot1_reg  <= slot1_next;
    end

    assign scan_eff   = (scan_period_reg == '0) ? sdmd_pkg::SCAN_W'(1) : scan_period_reg;
    assign scroll_eff = (scroll_period_reg == '0) ? sdmd_pkg::SCROLL_W'(1) : scroll_period_reg;
    assign scan_inc   = scan_cnt_reg + 1'b1;
    assign scroll_inc = scroll_cnt_reg + 1'b1;
    assign top_digit  = digits_reg[sdmd_pkg::DIGITS_W-1 -: 4];
    assign tp1        = sdmd_pkg::POS_W'(bcd_status.total) + 1'b1;

    always_comb
    begin
        logic [4:0] glyph_bits;
        for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
        begin
            glyph_bits = sdmd_pkg::glyph_row(top_digit, sdmd_pkg::ROW_W'(r));
            new_col[r] = (left_reg != '0) && glyph_bits[sdmd_pkg::COL_LAST - col_reg];
        end
    end

    always_comb
    begin
        for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
        begin
            frame_next[r] = frame_reg[r];
        end
        digits_next     = digits_reg;
        left_next       = left_reg;
        col_next        = col_reg;
        pos_next        = pos_reg;
        active_next     = active_reg;
        scan_row_next   = scan_row_reg;
        scan_cnt_next   = scan_cnt_reg;
        scroll_cnt_next = scroll_cnt_reg;
        step            = 1'b0;
        emit            = 1'b0;

        if (bcd_status.done)
        begin
            for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
            begin
                frame_next[r] = 5'd0;
            end
            digits_next     = bcd_digits;
            left_next       = bcd_status.total;
            col_next        = '0;
            pos_next        = (tp1 << 2) + tp1;
            active_next     = 1'b1;
            scroll_cnt_next = '0;
        end
        else if (load && !cmd.number[sdmd_pkg::NUMBER_W-1] && one_digit)
        begin
            for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
            begin
                frame_next[r] = sdmd_pkg::glyph_row(cmd.number[3:0], sdmd_pkg::ROW_W'(r));
            end
            active_next = 1'b0;
        end
        else if (tick)
        begin
            if (active_reg)
            begin
                step            = (scroll_inc >= scroll_eff);
                scroll_cnt_next = step ? '0 : scroll_inc;
            end
            if (step)
            begin
                if (pos_reg <= sdmd_pkg::POS_END)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                    for (int r = 0; r < sdmd_pkg::MATRIX_ROWS; r++)
                    begin
                        frame_next[r] = {frame_reg[r][3:0], new_col[r]};
                    end
                    if (left_reg != '0)
                    begin
                        if (col_reg == sdmd_pkg::COL_LAST)
                        begin
                            col_next    = '0;
                            digits_next = {digits_reg[sdmd_pkg::DIGITS_W-5:0], 4'd0};
                            left_next   = left_reg - 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            emit          = (scan_inc >= scan_eff);
            scan_cnt_next = emit ? '0 : scan_inc;
            if (emit)
            begin
                scan_row_next = (scan_row_reg == sdmd_pkg::ROW_LAST) ? '0 : scan_row_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        row_out.row_index = scan_row_reg;
        row_out.column_on = frame_next[scan_row_reg];
        row_out.scrolling = active_next;
    end

    assign pop    = (fifo_cnt_reg != '0) && drive.ready;
    assign wr_low = (fifo_cnt_reg == 2'd0) || ((fifo_cnt_reg == 2'd1) && pop);

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (emit)
        begin
            if (wr_low)
            begin
                slot0_next = row_out;
            end
            else
            begin
                slot1_next = row_out;
            end
        end
        unique case ({emit, pop})
            2'b10:   fifo_cnt_next = fifo_cnt_reg + 1'b1;
            2'b01:   fifo_cnt_next = fifo_cnt_reg - 1'b1;
            default: fifo_cnt_next = fifo_cnt_reg;
        endcase
    end

    assign drive.valid     = (fifo_cnt_reg != '0);
    assign drive.row_index = slot0_reg.row_index;
    assign drive.column_on = slot0_reg.column_on;
    assign drive.scrolling = slot0_reg.scrolling;

endmodule

>>> rtl/sdmd_bcd.sv
// Bit-serial binary to decimal converter with leading-zero alignment.
module sdmd_bcd
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sdmd_pkg::VALUE_W-1:0]     value,
    output sdmd_pkg::bcd_status_t            status,
    output logic [sdmd_pkg::DIGITS_W-1:0]    digits
);

    sdmd_pkg::bcd_state_t                 state_reg, state_next;
    logic [sdmd_pkg::VALUE_W-1:0]         bin_reg, bin_next;
    logic [sdmd_pkg::DIGITS_W-1:0]        bcd_reg, bcd_next;
    logic [sdmd_pkg::BITCNT_W-1:0]        cnt_reg, cnt_next;
    logic [sdmd_pkg::TOTAL_W-1:0]         total_reg, total_next;
    logic                                 ovf_reg, ovf_next;
    logic [sdmd_pkg::DIGITS_W-1:0]        adj;
    logic                                 top_zero;
    logic                                 done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdmd_pkg::BCD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        ovf_reg   <= ovf_next;
    end

    always_comb
    begin
        for (int i = 0; i < sdmd_pkg::MAX_DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
    end

    assign top_zero = (bcd_reg[sdmd_pkg::DIGITS_W-1 -: 4] == 4'd0);

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        done        = 1'b0;
        unique case (state_reg)
            sdmd_pkg::BCD_IDLE:
            begin
                if (start)
                begin
                    bin_next   = value;
                    bcd_next   = '0;
                    cnt_next   = sdmd_pkg::BITCNT_W'(sdmd_pkg::VALUE_W);
                    ovf_next   = 1'b0;
                    state_next = sdmd_pkg::BCD_SHIFT;
                end
            end
            sdmd_pkg::BCD_SHIFT:
            begin
                bcd_next = {adj[sdmd_pkg::DIGITS_W-2:0], bin_reg[sdmd_pkg::VALUE_W-1]};
                ovf_next = ovf_reg | adj[sdmd_pkg::DIGITS_W-1];
                bin_next = {bin_reg[sdmd_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == sdmd_pkg::BITCNT_W'(1))
                begin
                    total_next = sdmd_pkg::TOTAL_W'(sdmd_pkg::MAX_DIGITS);
                    state_next = sdmd_pkg::BCD_ALIGN;
                end
            end
            sdmd_pkg::BCD_ALIGN:
            begin
                if (ovf_reg || !top_zero)
                begin
                    done       = 1'b1;
                    state_next = sdmd_pkg::BCD_IDLE;
                end
                else
                begin
                    bcd_next   = {bcd_reg[sdmd_pkg::DIGITS_W-5:0], 4'd0};
                    total_next = total_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = sdmd_pkg::BCD_IDLE;
            end
        endcase
    end

    assign status.done  = done;
    assign status.busy  = (state_reg != sdmd_pkg::BCD_IDLE);
    assign status.total = total_reg;
    assign digits       = bcd_reg;

endmodule

>>> bench/tb.sv
// Self-checking bench for the scrolling digit matrix display: random loads and ticks, row checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdmd_pkg::*;

    typedef struct packed {
        logic        action;
        logic [31:0] number;
    } disp_req_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sdmd_cmd_if cmd_ch();
    sdmd_drive_if drive_ch();

    scrolling_digit_matrix_display_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd_ch),
        .drive(drive_ch)
    );

    // display model state
    logic [SCAN_W-1:0]   scan_len;
    logic [SCROLL_W-1:0] scroll_len;
    logic [3:0]          digit_q [MAX_DIGITS];
    int                  digit_cnt;
    int                  shift_pos;
    bit                  scroll_on;
    logic [4:0]          frame [MATRIX_ROWS];
    logic [ROW_W-1:0]    cur_row;
    logic [SCAN_W-1:0]   scan_cnt;
    logic [SCROLL_W-1:0] scroll_cnt;

    disp_req_t pending_q [$];
    drive_t    row_expect_q [$];

    bit calm;
    int hold_reqs;
    int hold_seen;
    int gap_left;
    int stall_left;
    logic nxt_valid;
    disp_req_t next_req;

    int fail_cnt;
    int loads_sent;
    int ticks_sent;
    int rows_seen;
    int settings_seen;

    function automatic void render_frame();
        int bits;
        int s;
        int g;
        for (int r = 0; r < MATRIX_ROWS; r++)
        begin
            bits = 0;
            for (int k = 0; k < digit_cnt && k < MAX_DIGITS; k++)
            begin
                s = shift_pos - (digit_cnt - k) * MATRIX_COLS;
                g = GLYPHS[digit_q[k]][r];
                if (s >= 0 && s < MATRIX_COLS)
                    bits = bits | (g >> s);
                else if (s < 0 && s > -MATRIX_COLS)
                    bits = bits | (g << (-s));
            end
            frame[r] = bits[4:0];
        end
    endfunction

    function automatic void load_value(logic [31:0] v);
        logic [3:0] low [MAX_DIGITS];
        int n;
        n = 0;
        if (v < 10)
        begin
            for (int r = 0; r < MATRIX_ROWS; r++)
                frame[r] = GLYPHS[v[3:0]][r];
            scroll_on = 0;
            return;
        end
        do
        begin
            low[n] = 4'(v % 10);
            v = v / 10;
            n++;
        end
        while (v != 0 && n < MAX_DIGITS);
        for (int i = 0; i < n; i++)
            digit_q[i] = low[n - 1 - i];
        digit_cnt = n;
        shift_pos = (n + 1) * MATRIX_COLS;
        scroll_on = 1;
        scroll_cnt = '0;
        render_frame();
    endfunction

    function automatic void model_request(logic action, logic [31:0] number);
        int p;
        drive_t exp_row;
        if (action == ACTION_LOAD)
        begin
            if (!number[31])
                load_value(number);
            return;
        end
        if (scroll_on)
        begin
            p = (scroll_len == 0) ? 1 : int'(scroll_len);
            scroll_cnt = scroll_cnt + 1'b1;
            if (int'(scroll_cnt) >= p)
            begin
                scroll_cnt = '0;
                if (shift_pos <= -MATRIX_COLS)
                    scroll_on = 0;
                else
                begin
                    shift_pos--;
                    render_frame();
                end
            end
        end
        p = (scan_len == 0) ? 1 : int'(scan_len);
        scan_cnt = scan_cnt + 1'b1;
        if (int'(scan_cnt) < p)
            return;
        scan_cnt = '0;
        exp_row.row_index = cur_row;
        exp_row.column_on = frame[cur_row];
        exp_row.scrolling = scroll_on;
        row_expect_q.push_back(exp_row);
        cur_row = (cur_row == ROW_LAST) ? '0 : cur_row + 1'b1;
    endfunction

    function automatic logic [31:0] pick_number();
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(10, 99);
            2: return $urandom_range(100, 999999);
            3: return $urandom_range(1000000000, 2147483647);
            4: return $urandom;
            5: return {1'b1, 31'($urandom)};
            default: return $urandom_range(10000000, 999999999);
        endcase
    endfunction

    function automatic void push_req(logic action, logic [31:0] number);
        disp_req_t req;
        req.action = action;
        req.number = number;
        pending_q.push_back(req);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_SCAN_PERIOD)
            scan_len = data[SCAN_W-1:0];
        else if (idx == REG_SCROLL_PERIOD)
            scroll_len = data[SCROLL_W-1:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic wait_empty();
        while (pending_q.size() != 0 || cmd_ch.valid || row_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (60) @(posedge clk);
    endtask

    task automatic run_phase(int scan, int scroll, int count, int load_odds,
                             bit pause_mid, bit squeeze);
        write_reg(REG_SCAN_PERIOD, CFG_W'(scan));
        write_reg(REG_SCROLL_PERIOD, CFG_W'(scroll));
        settings_seen++;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                wait_empty();
            if ($urandom_range(1, load_odds) == 1)
                push_req(ACTION_LOAD, pick_number());
            else
                push_req(ACTION_TICK, $urandom);
        end
        if (squeeze)
            hold_reqs++;
        drain();
    endtask

    always #2 clk = ~clk;

    // request driver and model update
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                model_request(cmd_ch.action, cmd_ch.number);
                if (cmd_ch.action == ACTION_LOAD)
                    loads_sent++;
                else
                    ticks_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                nxt_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (!calm && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 10) - 1;
                else if (pending_q.size() != 0)
                begin
                    next_req = pending_q.pop_front();
                    nxt_valid = 1'b1;
                    cmd_ch.action <= next_req.action;
                    cmd_ch.number <= next_req.number;
                end
                cmd_ch.valid <= nxt_valid;
            end
        end
    end

    // row monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drive_ch.valid && drive_ch.ready)
            begin
                rows_seen++;
                if (row_expect_q.size() == 0)
                begin
                    $error("unexpected row: row_index %0d column_on %b scrolling %0d",
                           drive_ch.row_index, drive_ch.column_on, drive_ch.scrolling);
                    fail_cnt++;
                end
                else
                begin
                    drive_t exp_row;
                    exp_row = row_expect_q.pop_front();
                    if (drive_ch.row_index !== exp_row.row_index)
                    begin
                        $error("row_index: expected %0d, got %0d",
                               exp_row.row_index, drive_ch.row_index);
                        fail_cnt++;
                    end
                    if (drive_ch.column_on !== exp_row.column_on)
                    begin
                        $error("column_on: expected %b, got %b",
                               exp_row.column_on, drive_ch.column_on);
                        fail_cnt++;
                    end
                    if (drive_ch.scrolling !== exp_row.scrolling)
                    begin
                        $error("scrolling: expected %0d, got %0d",
                               exp_row.scrolling, drive_ch.scrolling);
                        fail_cnt++;
                    end
                end
            end
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                drive_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                drive_ch.ready <= 1'b0;
            end
            else
                drive_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACTION_TICK;
        cmd_ch.number = '0;
        drive_ch.ready = 1'b0;
        scan_len = SCAN_PERIOD_RST;
        scroll_len = SCROLL_PERIOD_RST;
        digit_cnt = 0;
        shift_pos = 0;
        scroll_on = 0;
        for (int r = 0; r < MATRIX_ROWS; r++)
            frame[r] = '0;
        cur_row = '0;
        scan_cnt = '0;
        scroll_cnt = '0;
        calm = 0;
        hold_reqs = 0;
        hold_seen = 0;
        gap_left = 0;
        stall_left = 0;
        fail_cnt = 0;
        loads_sent = 0;
        ticks_sent = 0;
        rows_seen = 0;
        settings_seen = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset periods: one row after 250 ticks
        for (int i = 0; i < 252; i++)
            push_req(ACTION_TICK, $urandom);
        push_req(ACTION_LOAD, 32'd5);
        drain();

        write_reg(REG_SCAN_PERIOD, CFG_W'(1));
        write_reg(REG_SCROLL_PERIOD, CFG_W'(1));
        settings_seen++;
        push_req(ACTION_TICK, 32'h0000_0000);
        push_req(ACTION_TICK, 32'hFFFF_FFFF);
        push_req(ACTION_LOAD, 32'd0);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'd9);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'hFFFF_FFFF);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'h8000_0000);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'd10);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'd2147483647);
        for (int i = 0; i < 4; i++)
            push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'd7);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_LOAD, 32'd1000000000);
        push_req(ACTION_TICK, 32'd0);
        push_req(ACTION_TICK, 32'd0);
        drain();

        run_phase(1, 1, 200, 25, 0, 1);
        run_phase(0, 0, 80, 70, 1, 0);
        run_phase(3, 2, 120, 30, 0, 0);
        run_phase(2, 16777215, 50, 20, 0, 0);
        run_phase(65535, 5, 40, 10, 0, 0);
        run_phase(1, 3, 120, 40, 0, 0);
        run_phase(4, 1, 100, 30, 0, 0);
        calm = 1;
        run_phase(1, 2, 150, 35, 0, 0);

        $display("Sent %0d loads and %0d ticks under %0d period settings; checked %0d rows.",
                 loads_sent, ticks_sent, settings_seen, rows_seen);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/sdmd_pkg.sv
rtl/sdmd_cmd_if.sv
rtl/sdmd_drive_if.sv
rtl/sdmd_bcd.sv
rtl/scrolling_digit_matrix_display_unit.sv
bench/tb.sv
